### rtl/pal_pkg.sv
// Shared types and constants for the positional array list.
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int OP_W              = 3;
  localparam int POS_W             = 7;
  localparam int VALUE_W           = 32;
  localparam int LEN_W             = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic rot;
  } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/positional_array_list_unit.sv
// Top level of the positional array list: request decode, scan control and the row of cells.
//
// Usage: present op, position and value with start high; the item is taken at
// a rising edge where start is high and busy is low. Exactly one result follows,
// shown for one cycle with done high: status, read_value, found_position,
// list_length and is_empty. The receiver cannot stall; the result is gone after
// that cycle.
// Latency: insert, delete, clear, unused codes and a get at a bad position give
// their result in the cycle after acceptance, and a new item may be taken then.
// A valid get and every locate rotate the ring of CAPACITY cells once through
// cell zero, one cell a cycle; busy stays high for the whole rotation and done
// rises as it ends, with the ring back in place. The length of that rotation
// sets the rate for reads.
// Reset (synchronous, rst high) empties the list and drops busy and done; cell
// contents are not cleared, as only entries below the length are ever read.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list_unit import pal_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [OP_W-1:0]           op,
  input  wire logic [POS_W-1:0]          position,
  input  wire logic signed [VALUE_W-1:0] value,
  output logic                           done,
  output logic                           status,
  output logic signed [VALUE_W-1:0]      read_value,
  output logic [LEN_W-1:0]               found_position,
  output logic [LEN_W-1:0]               list_length,
  output logic                           is_empty
);

  localparam int EW = ELEMENT_WIDTH;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (CW > POS_W) ? CW : POS_W;
  localparam logic [IW-1:0] LAST_K = IW'(CAPACITY - 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t         state;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic [IW-1:0]  k;
  logic           s_locate;
  logic [KW-1:0]  s_p;
  logic [EW-1:0]  s_elem;
  logic           hit;

  logic [EW-1:0]  cell_q [CAPACITY];
  cell_cmd_t      cmd;

  logic                    accept;
  logic [KW-1:0]           pos_k;
  logic [KW-1:0]           count_k;
  logic [KW-1:0]           p;
  logic [KW-1:0]           k_ext;
  logic                    pos_nz;
  logic                    ins_ok;
  logic                    del_ok;
  logic [EW+VALUE_W-1:0]   val_ext;
  logic [EW-1:0]           elem;
  logic [EW+VALUE_W-1:0]   rd_ext;
  logic                    ins_go;
  logic                    del_go;

  assign busy    = (state == ST_SCAN);
  assign accept  = start && !busy;
  assign pos_k   = KW'(position);
  assign count_k = KW'(count);
  assign p       = pos_k - KW'(1);
  assign k_ext   = KW'(k);
  assign pos_nz  = (position != '0);
  assign ins_ok  = pos_nz && (pos_k <= count_k + KW'(1)) && (count_k < KW'(CAPACITY));
  assign del_ok  = pos_nz && (pos_k <= count_k);
  assign val_ext = {{EW{1'b0}}, value};
  assign elem    = val_ext[EW-1:0];
  assign rd_ext  = {{VALUE_W{1'b0}}, cell_q[0]};

  assign ins_go = accept && (op == OP_INSERT) && ins_ok;
  assign del_go = accept && (op == OP_DELETE) && del_ok;

  always_comb begin
    cmd.ins = ins_go;
    cmd.del = del_go;
    cmd.rot = busy;
  end

  always_comb begin
    count_next = count;
    if (accept) begin
      unique case (op)
        OP_INSERT: if (ins_ok) count_next = count + CW'(1);
        OP_DELETE: if (del_ok) count_next = count - CW'(1);
        OP_CLEAR:  count_next = '0;
        default:   count_next = count;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pal_cell #(
      .EW  (EW),
      .KW  (KW),
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .p     (p),
      .elem  (elem),
      .left  (cell_q[(i + CAPACITY - 1) % CAPACITY]),
      .right (cell_q[(i + 1) % CAPACITY]),
      .data  (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
      k     <= '0;
      hit   <= 1'b0;
    end else begin
      count <= count_next;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            read_value     <= '0;
            found_position <= '0;
            list_length    <= LEN_W'(count_next);
            is_empty       <= (count_next == '0);
            s_p            <= p;
            s_elem         <= elem;
            s_locate       <= (op == OP_LOCATE);
            k              <= '0;
            hit            <= 1'b0;
            unique case (op)
              OP_INSERT: begin
                status <= !ins_ok;
                done   <= 1'b1;
              end
              OP_DELETE: begin
                status <= !del_ok;
                done   <= 1'b1;
              end
              OP_GET: begin
                status <= !del_ok;
                done   <= !del_ok;
                if (del_ok) begin
                  state <= ST_SCAN;
                end
              end
              OP_LOCATE: begin
                status <= 1'b0;
                done   <= 1'b0;
                state  <= ST_SCAN;
              end
              OP_CLEAR: begin
                status <= 1'b0;
                done   <= 1'b1;
              end
              default: begin
                status <= 1'b1;
                done   <= 1'b1;
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (!s_locate && k_ext == s_p) begin
            read_value <= rd_ext[VALUE_W-1:0];
          end
          if (s_locate && !hit && k_ext < count_k && cell_q[0] == s_elem) begin
            hit            <= 1'b1;
            found_position <= LEN_W'(k_ext + KW'(1));
          end
          if (k == LAST_K) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            k <= k + IW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_scan_ends_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("scan ended without a result");

  a_no_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result shown while scan in progress");

  a_count_stable_in_scan: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(count))
    else $error("entry count changed during scan");
`endif

endmodule

`default_nettype wire

### rtl/pal_cell.sv
// One storage cell of the list: holds a single entry and trades it with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module pal_cell import pal_pkg::*; #(
  parameter int EW  = ELEMENT_WIDTH_DEF,
  parameter int KW  = 8,
  parameter int IDX = 0
) (
  input  wire logic            clk,
  input  wire cell_cmd_t       cmd,
  input  wire logic [KW-1:0]   p,
  input  wire logic [EW-1:0]   elem,
  input  wire logic [EW-1:0]   left,
  input  wire logic [EW-1:0]   right,
  output logic      [EW-1:0]   data
);

  localparam logic [KW-1:0] MY_IDX = KW'(IDX);

  always_ff @(posedge clk) begin
    priority if (cmd.rot) begin
      data <= right;
    end else if (cmd.ins && MY_IDX == p) begin
      data <= elem;
    end else if (cmd.ins && MY_IDX > p) begin
      data <= left;
    end else if (cmd.del && MY_IDX >= p) begin
      data <= right;
    end else begin
      data <= data;
    end
  end

endmodule

`default_nettype wire
